>>> design/njtb_pkg.sv
// Shared widths, register codes and helpers for the neighbor-joining tree builder.
package njtb_pkg;

  localparam int MAX_TAXA_DEF = 64;
  localparam int ID_W         = 7;
  localparam int DATA_W       = 32;
  localparam int SUM_W        = 40;
  localparam int PROD_W       = 40;
  localparam int KEY_W        = 42;
  localparam int NUM_W        = 42;
  localparam int DEN_W        = 8;
  localparam int BR_W         = 44;
  localparam int OUT_W        = 80;

  localparam logic REG_TAXA  = 1'b0;
  localparam logic REG_CLAMP = 1'b1;

  function automatic logic [DATA_W-1:0] sat32(input logic signed [BR_W-1:0] x);
    logic signed [BR_W-1:0] hi;
    logic signed [BR_W-1:0] lo;
    hi = BR_W'(64'sd2147483647);
    lo = -BR_W'(64'sd2147483648);
    if (x > hi) begin
      sat32 = 32'h7FFF_FFFF;
    end else if (x < lo) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = x[DATA_W-1:0];
    end
  endfunction

endpackage

>>> design/njtb_div.sv
// Bit-serial floor divider: signed dividend by a small positive divisor.
module njtb_div import njtb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0]        den_i,
  output logic                    done_o,
  output logic signed [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic             neg_q;
  logic [NUM_W-1:0] mag_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rem_q;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_q[DEN_W-1:0], mag_q[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NUM_W-1];
      mag_q <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      quo_q <= '0;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      mag_q <= {mag_q[NUM_W-2:0], 1'b0};
      quo_q <= {quo_q[NUM_W-2:0], fits};
      rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
    end
  end

  // floor for negative dividends: -(q + (rem != 0))
  assign quot_o = neg_q ? -$signed(quo_q + NUM_W'(rem_q != '0)) : $signed(quo_q);
  assign done_o = done_q;

endmodule

>>> design/neighbor_joining_tree_builder.sv
// Neighbor-joining tree builder: matrix load, pair search, branch and distance update.
// The block takes an n-by-n Q16.16 distance matrix one entry per cycle in row-major order,
// keeping row sums as it goes. After the last entry it is not ready while it runs the joins:
// each round scans all ordered pairs of active slots through one multiplier, fetches the pair
// and divides for the branch length bit-serially, then updates every other active cluster in
// turn on the single distance memory; a final pass gives the closing record. Results leave
// through an output register, so the sequencer only waits when a record is still untaken
// when the next one is ready.
module neighbor_joining_tree_builder import njtb_pkg::*; #(
  parameter int MAX_TAXA = MAX_TAXA_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,   // dist_value[31:0]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,   // left_id[6:0], right_id[13:7],
                                            // left_branch[45:14], right_branch[77:46]
  output logic              m_axis_tlast,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int IDX_W  = (MAX_TAXA > 1) ? $clog2(MAX_TAXA) : 1;
  localparam int ADDR_W = 2 * IDX_W;
  localparam logic [ID_W-1:0] MAX_N = ID_W'(MAX_TAXA);

  typedef enum logic [12:0] {
    ST_LOAD   = 13'b0000000000001,
    ST_SROW   = 13'b0000000000010,
    ST_SCAN   = 13'b0000000000100,
    ST_SDRAIN = 13'b0000000001000,
    ST_FETCH  = 13'b0000000010000,
    ST_DIV    = 13'b0000000100000,
    ST_BR     = 13'b0000001000000,
    ST_EMIT   = 13'b0000010000000,
    ST_UPD    = 13'b0000100000000,
    ST_UFIN   = 13'b0001000000000,
    ST_LSCAN  = 13'b0010000000000,
    ST_LFETCH = 13'b0100000000000,
    ST_LEMIT  = 13'b1000000000000
  } state_e;

  state_e state_q;

  // configuration
  logic [ID_W-1:0]  taxa_q;
  logic             clamp_q;
  logic             cfg_wr;
  logic [ID_W-1:0]  taxa_wr;
  logic [IDX_W-1:0] n_m1;

  // memories
  logic [DATA_W-1:0] dmem [2**ADDR_W];
  logic [SUM_W-1:0]  rsmem [MAX_TAXA];
  logic [ID_W-1:0]   idmem [MAX_TAXA];
  logic              d_we, rs_we, id_we;
  logic [ADDR_W-1:0] d_waddr, d_raddr;
  logic [DATA_W-1:0] d_wdata, d_rdata_q;
  logic [IDX_W-1:0]  rs_waddr, rs_raddr, id_waddr, id_raddr;
  logic [SUM_W-1:0]  rs_wdata, rs_rdata_q;
  logic [ID_W-1:0]   id_wdata, id_rdata_q;

  // load
  logic [IDX_W-1:0] lrow_q, lcol_q;
  logic [SUM_W-1:0] acc_q, acc_next;
  logic             s_acc;

  // join state
  logic [MAX_TAXA-1:0] active_q;
  logic [ID_W-1:0]     next_id_q, rem_q, m_q;
  logic [IDX_W-1:0]    si_q, sj_q, bi_q, bj_q, k_q, la_q, lb_q, p_idx, q_idx;
  logic [2:0]          ph_q;
  logic                found_q, seen_q;
  logic [SUM_W-1:0]    si_sum_q, sj_sum_q, sbi_q, sbj_q, rsk_q, nsum_q;
  logic                v1_q, v2_q, scan_vld;
  logic [IDX_W-1:0]    i1_q, j1_q, i2_q, j2_q;
  logic signed [PROD_W-1:0] prod_c, prod_q;
  logic signed [KEY_W-1:0]  key_c, best_q;
  logic [DATA_W-1:0]   dd_q, v1d_q, v2d_q, w1_q, w2_q, nd_q, nd_c;
  logic [ID_W-1:0]     idl_q, idr_q;
  logic [DATA_W-1:0]   b1_q, b2_q;
  logic [SUM_W-1:0]    rs_upd;
  logic                upd_skip, out_free;

  // divider
  logic                    div_start, div_done;
  logic signed [NUM_W-1:0] div_num, div_quot;

  // output register
  logic              m_valid_q, m_last_q;
  logic [OUT_W-1:0]  m_data_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_CLAMP) ? {31'b0, clamp_q} : {25'b0, taxa_q};

  always_comb begin
    taxa_wr = pwdata[ID_W-1:0];
    if (taxa_wr < ID_W'(3)) taxa_wr = ID_W'(3);
    if (taxa_wr > MAX_N) taxa_wr = MAX_N;
  end

  assign n_m1     = IDX_W'(taxa_q - 1'b1);
  assign s_axis_tready = (state_q == ST_LOAD);
  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign acc_next = ((lcol_q == '0) ? '0 : acc_q) + {{(SUM_W-DATA_W){s_axis_tdata[31]}},
                                                      s_axis_tdata};
  assign out_free = !m_valid_q || m_axis_tready;
  assign p_idx    = (bi_q < bj_q) ? bi_q : bj_q;
  assign q_idx    = (bi_q < bj_q) ? bj_q : bi_q;
  assign scan_vld = (state_q == ST_SCAN) && active_q[sj_q] && (sj_q != si_q);
  assign upd_skip = !active_q[k_q] || (k_q == bi_q) || (k_q == bj_q);

  // one shared multiplier: (r-2) times the distance just read
  assign prod_c = $signed({1'b0, m_q}) * $signed(d_rdata_q);
  assign key_c  = KEY_W'(prod_q) - KEY_W'($signed(si_sum_q)) - KEY_W'($signed(sj_sum_q));
  assign div_num = NUM_W'(prod_q) + NUM_W'($signed(sbi_q)) - NUM_W'($signed(sbj_q));
  assign div_start = (state_q == ST_FETCH) && (ph_q == 3'd3);
  assign rs_upd = rsk_q + {{(SUM_W-DATA_W){nd_q[31]}}, nd_q}
                - {{(SUM_W-DATA_W){w1_q[31]}}, w1_q} - {{(SUM_W-DATA_W){w2_q[31]}}, w2_q};

  // new distance: floor((d(i,k) + d(j,k) - d) / 2), clamp, saturate
  always_comb begin
    logic signed [DATA_W+1:0] s;
    logic signed [BR_W-1:0]   h;
    s = $signed({{2{v1d_q[31]}}, v1d_q}) + $signed({{2{v2d_q[31]}}, v2d_q})
      - $signed({{2{dd_q[31]}}, dd_q});
    h = BR_W'(s >>> 1);
    if (clamp_q && h < 0) h = '0;
    nd_c = sat32(h);
  end

  njtb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   ({m_q, 1'b0}),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // memory port steering
  always_comb begin
    d_we = 1'b0; d_waddr = '0; d_wdata = '0; d_raddr = {si_q, sj_q};
    rs_we = 1'b0; rs_waddr = '0; rs_wdata = '0; rs_raddr = sj_q;
    id_we = 1'b0; id_waddr = '0; id_wdata = '0; id_raddr = bi_q;
    unique case (state_q)
      ST_LOAD: begin
        if (s_acc) begin
          d_we = 1'b1; d_waddr = {lrow_q, lcol_q}; d_wdata = s_axis_tdata;
          if (lcol_q == n_m1) begin
            rs_we = 1'b1; rs_waddr = lrow_q; rs_wdata = acc_next;
            id_we = 1'b1; id_waddr = lrow_q; id_wdata = ID_W'(lrow_q);
          end
        end
      end
      ST_SROW: rs_raddr = si_q;
      ST_FETCH: begin
        d_raddr = {bi_q, bj_q};
        rs_raddr = (ph_q == 3'd0) ? bi_q : bj_q;
        id_raddr = (ph_q == 3'd0) ? bi_q : bj_q;
      end
      ST_UPD: begin
        rs_raddr = k_q;
        case (ph_q)
          3'd0: d_raddr = {bi_q, k_q};
          3'd1: d_raddr = {bj_q, k_q};
          3'd2: d_raddr = {k_q, bi_q};
          3'd3: d_raddr = {k_q, bj_q};
          3'd5: begin
            d_we = 1'b1; d_waddr = {p_idx, k_q}; d_wdata = nd_q;
            rs_we = 1'b1; rs_waddr = k_q; rs_wdata = rs_upd;
          end
          3'd6: begin
            d_we = 1'b1; d_waddr = {k_q, p_idx}; d_wdata = nd_q;
          end
          default: ;
        endcase
      end
      ST_UFIN: begin
        d_we = 1'b1; d_waddr = {p_idx, p_idx}; d_wdata = '0;
        rs_we = 1'b1; rs_waddr = p_idx; rs_wdata = nsum_q;
        id_we = 1'b1; id_waddr = p_idx; id_wdata = next_id_q;
      end
      ST_LFETCH: begin
        d_raddr = {la_q, lb_q};
        id_raddr = (ph_q == 3'd0) ? la_q : lb_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (d_we) dmem[d_waddr] <= d_wdata;
    d_rdata_q <= dmem[d_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rs_we) rsmem[rs_waddr] <= rs_wdata;
    rs_rdata_q <= rsmem[rs_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (id_we) idmem[id_waddr] <= id_wdata;
    id_rdata_q <= idmem[id_raddr];
  end

  // search pipeline and datapath registers
  always_ff @(posedge clk_i) begin
    i1_q <= si_q; j1_q <= sj_q;
    i2_q <= i1_q; j2_q <= j1_q;
    sj_sum_q <= rs_rdata_q;
    prod_q   <= prod_c;
    if (s_acc) acc_q <= acc_next;
    if (state_q == ST_SCAN && ph_q == 3'd0) si_sum_q <= rs_rdata_q;
    if (v2_q && (!found_q || key_c < best_q)) begin
      best_q <= key_c; bi_q <= i2_q; bj_q <= j2_q;
    end
    if (state_q == ST_FETCH && ph_q == 3'd1) begin
      dd_q <= d_rdata_q; sbi_q <= rs_rdata_q; idl_q <= id_rdata_q;
    end
    if (state_q == ST_FETCH && ph_q == 3'd2) begin
      sbj_q <= rs_rdata_q; idr_q <= id_rdata_q;
    end
    if (state_q == ST_BR) begin : br
      logic signed [BR_W-1:0] b1, b2;
      b1 = BR_W'(div_quot);
      b2 = BR_W'($signed(dd_q)) - b1;
      if (clamp_q) begin
        if (b1 < 0) begin
          b2 = b2 + b1; b1 = '0;
        end
        if (b2 < 0) begin
          b1 = b1 + b2;
          if (b1 < 0) b1 = '0;
          b2 = '0;
        end
      end
      b1_q <= sat32(b1);
      b2_q <= sat32(b2);
    end
    if (state_q == ST_UPD) begin
      if (ph_q == 3'd1) begin v1d_q <= d_rdata_q; rsk_q <= rs_rdata_q; end
      if (ph_q == 3'd2) v2d_q <= d_rdata_q;
      if (ph_q == 3'd3) w1_q <= d_rdata_q;
      if (ph_q == 3'd4) begin w2_q <= d_rdata_q; nd_q <= nd_c; end
    end
    if (state_q == ST_LFETCH && ph_q == 3'd1) begin
      dd_q <= d_rdata_q; idl_q <= id_rdata_q;
    end
    if (state_q == ST_LFETCH && ph_q == 3'd2) idr_q <= id_rdata_q;
    if (state_q == ST_EMIT && out_free) nsum_q <= '0;
    if (state_q == ST_UPD && ph_q == 3'd5) nsum_q <= nsum_q + {{(SUM_W-DATA_W){nd_q[31]}}, nd_q};
    if (state_q == ST_LSCAN && active_q[k_q]) begin
      if (!seen_q) la_q <= k_q;
      else lb_q <= k_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_EMIT || state_q == ST_LEMIT) && out_free) begin
      if (state_q == ST_EMIT) m_data_q <= {2'b0, b2_q, b1_q, idr_q, idl_q};
      else m_data_q <= {2'b0, 32'b0, dd_q, idr_q, idl_q};
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      taxa_q    <= MAX_N;
      clamp_q   <= 1'b0;
      lrow_q    <= '0;
      lcol_q    <= '0;
      active_q  <= '0;
      next_id_q <= '0;
      rem_q     <= '0;
      m_q       <= '0;
      si_q      <= '0;
      sj_q      <= '0;
      k_q       <= '0;
      ph_q      <= '0;
      found_q   <= 1'b0;
      seen_q    <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      m_valid_q <= 1'b0;
      m_last_q  <= 1'b0;
    end else begin
      v1_q <= scan_vld;
      v2_q <= v1_q;
      if (v2_q) found_q <= 1'b1;
      if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;

      if (cfg_wr) begin
        if (paddr[2] == REG_TAXA) begin
          taxa_q <= taxa_wr;
          lrow_q <= '0;
          lcol_q <= '0;
        end else begin
          clamp_q <= pwdata[0];
        end
      end

      unique case (state_q)
        ST_LOAD: begin
          if (s_acc) begin
            if (lcol_q == n_m1) begin
              lcol_q <= '0;
              if (lrow_q == n_m1) begin
                lrow_q <= '0;
                for (int k = 0; k < MAX_TAXA; k++) active_q[k] <= (ID_W'(k) < taxa_q);
                next_id_q <= taxa_q;
                rem_q     <= taxa_q;
                m_q       <= taxa_q - ID_W'(2);
                si_q      <= '0;
                sj_q      <= '0;
                found_q   <= 1'b0;
                state_q   <= ST_SROW;
              end else begin
                lrow_q <= lrow_q + 1'b1;
              end
            end else begin
              lcol_q <= lcol_q + 1'b1;
            end
          end
        end
        ST_SROW: begin
          ph_q <= '0;
          if (active_q[si_q]) begin
            state_q <= ST_SCAN;
          end else if (si_q == n_m1) begin
            state_q <= ST_SDRAIN;
          end else begin
            si_q <= si_q + 1'b1;
          end
        end
        ST_SCAN: begin
          ph_q <= 3'd1;
          if (sj_q == n_m1) begin
            sj_q <= '0;
            if (si_q == n_m1) begin
              ph_q    <= '0;
              state_q <= ST_SDRAIN;
            end else begin
              si_q    <= si_q + 1'b1;
              state_q <= ST_SROW;
            end
          end else begin
            sj_q <= sj_q + 1'b1;
          end
        end
        ST_SDRAIN: begin
          // wait for the last pairs to leave the compare pipeline
          ph_q <= ph_q + 1'b1;
          if (ph_q == 3'd1) begin
            ph_q    <= '0;
            state_q <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          ph_q <= ph_q + 1'b1;
          if (ph_q == 3'd3) state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) state_q <= ST_BR;
        end
        ST_BR: state_q <= ST_EMIT;
        ST_EMIT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_last_q  <= 1'b0;
            k_q       <= '0;
            ph_q      <= '0;
            state_q   <= ST_UPD;
          end
        end
        ST_UPD: begin
          if ((ph_q == 3'd0 && upd_skip) || ph_q == 3'd6) begin
            ph_q <= '0;
            if (k_q == n_m1) state_q <= ST_UFIN;
            else k_q <= k_q + 1'b1;
          end else begin
            ph_q <= ph_q + 1'b1;
          end
        end
        ST_UFIN: begin
          active_q[q_idx] <= 1'b0;
          next_id_q <= next_id_q + 1'b1;
          rem_q     <= rem_q - 1'b1;
          m_q       <= rem_q - ID_W'(3);
          si_q      <= '0;
          sj_q      <= '0;
          k_q       <= '0;
          seen_q    <= 1'b0;
          found_q   <= 1'b0;
          state_q   <= (rem_q == ID_W'(3)) ? ST_LSCAN : ST_SROW;
        end
        ST_LSCAN: begin
          if (active_q[k_q]) seen_q <= 1'b1;
          ph_q <= '0;
          if (k_q == n_m1) state_q <= ST_LFETCH;
          else k_q <= k_q + 1'b1;
        end
        ST_LFETCH: begin
          ph_q <= ph_q + 1'b1;
          if (ph_q == 3'd2) state_q <= ST_LEMIT;
        end
        ST_LEMIT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_last_q  <= 1'b1;
            state_q   <= ST_LOAD;
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule

>>> design/njtb_checker.sv
// Port-level checks for the neighbor-joining tree builder, bound to the top level.
module njtb_checker import njtb_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             m_axis_tlast,
  input logic             pready
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result item changed while stalled");

  // a join record that is not the last means the join phase is still running
  a_busy_mid_tree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input taken in the middle of a tree");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind neighbor_joining_tree_builder njtb_checker u_njtb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .pready        (pready)
);

>>> sim/tb_top.sv
// Self-checking testbench for the neighbor-joining tree builder.
`timescale 1ns / 100ps

module tb_top;
  import njtb_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0]   lid;
    logic [ID_W-1:0]   rid;
    logic [DATA_W-1:0] lbr;
    logic [DATA_W-1:0] rbr;
    logic              fin;
  } join_rec_t;

  typedef enum logic [1:0] {OP_TAXA, OP_CLAMP, OP_ENTRY, OP_ENTRY_TYPED} row_op_e;

  typedef struct packed {
    row_op_e     op;
    logic [31:0] val;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  neighbor_joining_tree_builder dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the block state
  int     nj_dist [64][64];
  longint nj_rsum [64];
  bit     nj_act  [64];
  int     nj_cid  [64];
  int     nj_taxa = 64;
  int     nj_clamp = 0;
  int     nj_lpos = 0;

  join_rec_t tree_q[$];   // records still to arrive
  join_rec_t fresh_q[$];  // records caused by the latest item

  int errors = 0;
  int items_sent = 0;
  int recs_seen = 0;
  int trees_built = 0;
  int mat [64][64];

  function automatic longint sat32l(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic join_rec_t mk_rec(int a, int b, longint x, longint y, bit f);
    join_rec_t r;
    r.lid = a[ID_W-1:0];
    r.rid = b[ID_W-1:0];
    r.lbr = DATA_W'(sat32l(x));
    r.rbr = DATA_W'(sat32l(y));
    r.fin = f;
    return r;
  endfunction

  task automatic build_tree();
    int n, bi, bj, p, q, a, b, seen, nid, rem;
    longint m, best, key, d, b1, b2, nsum, nd;
    bit found;
    n = nj_taxa;
    for (int k = 0; k < 64; k++) begin
      nj_act[k] = (k < n);
      nj_cid[k] = (k < n) ? k : 0;
    end
    nid = n;
    rem = n;
    while (rem > 2) begin
      m = rem - 2;
      found = 0; best = 0; bi = 0; bj = 0; nsum = 0;
      for (int i = 0; i < n; i++) begin
        if (!nj_act[i]) continue;
        for (int j = 0; j < n; j++) begin
          if (j == i || !nj_act[j]) continue;
          key = m * longint'(nj_dist[i][j]) - nj_rsum[i] - nj_rsum[j];
          if (!found || key < best) begin
            found = 1; best = key; bi = i; bj = j;
          end
        end
      end
      d = nj_dist[bi][bj];
      b1 = floor_div(m * d + nj_rsum[bi] - nj_rsum[bj], 2 * m);
      b2 = d - b1;
      if (nj_clamp != 0) begin
        if (b1 < 0) begin b2 += b1; b1 = 0; end
        if (b2 < 0) begin
          b1 += b2;
          if (b1 < 0) b1 = 0;
          b2 = 0;
        end
      end
      fresh_q.push_back(mk_rec(nj_cid[bi], nj_cid[bj], b1, b2, 1'b0));
      p = (bi < bj) ? bi : bj;
      q = (bi < bj) ? bj : bi;
      for (int k = 0; k < n; k++) begin
        if (!nj_act[k] || k == bi || k == bj) continue;
        nd = floor_div(longint'(nj_dist[bi][k]) + nj_dist[bj][k] - d, 2);
        if (nj_clamp != 0 && nd < 0) nd = 0;
        nd = sat32l(nd);
        nj_rsum[k] += nd - nj_dist[k][bi] - nj_dist[k][bj];
        nj_dist[p][k] = int'(nd);
        nj_dist[k][p] = int'(nd);
        nsum += nd;
      end
      nj_dist[p][p] = 0;
      nj_rsum[p] = nsum;
      nj_rsum[q] = 0;
      nj_act[q] = 0;
      nj_cid[q] = 0;
      nj_cid[p] = nid & 8'h7F;
      nid = (nid + 1) & 8'h7F;
      rem--;
    end
    a = 0; b = 0; seen = 0;
    for (int k = 0; k < n; k++) begin
      if (!nj_act[k]) continue;
      if (seen == 0) a = k;
      else if (seen == 1) b = k;
      seen++;
    end
    fresh_q.push_back(mk_rec(nj_cid[a], nj_cid[b], nj_dist[a][b], 0, 1'b1));
    trees_built++;
  endtask

  task automatic absorb_entry(logic [31:0] v);
    int n, pos;
    n = nj_taxa;
    pos = nj_lpos;
    if (pos >= n * n) pos = 0;
    if (pos == 0) foreach (nj_rsum[k]) nj_rsum[k] = 0;
    nj_dist[pos / n][pos % n] = int'(v);
    nj_rsum[pos / n] += longint'(signed'(v));
    pos++;
    if (pos < n * n) begin
      nj_lpos = pos;
    end else begin
      nj_lpos = 0;
      build_tree();
    end
  endtask

  // Sender gaps: mostly none, some short, a few long
  bit quiet_tx = 0;
  function automatic int tx_gap();
    int roll;
    if ($urandom_range(0, 199) == 0) quiet_tx = ~quiet_tx;
    if (quiet_tx) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called at a rising edge with no pending drive on tvalid in this step.
  task automatic send_entry(logic [31:0] v, bit more, bit typed,
                            input join_rec_t fix[$]);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    fresh_q.delete();
    absorb_entry(v);
    if (typed) fresh_q = fix;
    foreach (fresh_q[k]) tree_q.push_back(fresh_q[k]);
    items_sent++;
    gap = more ? tx_gap() : 1;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (tree_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic reg_write(logic idx, logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_TAXA) begin
      nj_taxa = (val[6:0] < 3) ? 3 : (val[6:0] > 64) ? 64 : int'(val[6:0]);
      nj_lpos = 0;
    end else begin
      nj_clamp = val[0];
    end
    @(posedge clk_i);
  endtask

  task automatic send_matrix(int n, int kind);
    join_rec_t none[$];
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        case (kind)
          0: mat[r][c] = (r == c) ? 0 : (c < r) ? mat[c][r] : $urandom_range(0, 20 << 16);
          1: mat[r][c] = $urandom;
          default: mat[r][c] = int'($urandom_range(0, 16 << 16)) - (4 << 16);
        endcase
      end
    end
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        send_entry(mat[r][c], !(r == n - 1 && c == n - 1), 1'b0, none);
  endtask

  // Result checker and receiver stalls
  int  stall_cnt = 0;
  bit  quiet_rx = 0;
  always @(posedge clk_i) begin
    if ($urandom_range(0, 299) == 0) quiet_rx <= ~quiet_rx;
    if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!quiet_rx) begin
        case ($urandom_range(0, 99)) inside
          [0:14]:  stall_cnt <= $urandom_range(1, 3);
          [15:17]: stall_cnt <= $urandom_range(8, 40);
          default: stall_cnt <= 0;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    join_rec_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.lid = m_axis_tdata[6:0];
      got.rid = m_axis_tdata[13:7];
      got.lbr = m_axis_tdata[45:14];
      got.rbr = m_axis_tdata[77:46];
      got.fin = m_axis_tlast;
      recs_seen++;
      if (tree_q.size() == 0) begin
        $display("%0t: unexpected record, exp none got %p", $time, got);
        errors++;
      end else begin
        want = tree_q[0];
        tree_q.delete(0);
        if (got.lid !== want.lid)
          $display("%0t: left_id exp %0d got %0d", $time, want.lid, got.lid);
        if (got.rid !== want.rid)
          $display("%0t: right_id exp %0d got %0d", $time, want.rid, got.rid);
        if (got.lbr !== want.lbr)
          $display("%0t: left_branch exp %h got %h", $time, want.lbr, got.lbr);
        if (got.rbr !== want.rbr)
          $display("%0t: right_branch exp %h got %h", $time, want.rbr, got.rbr);
        if (got.fin !== want.fin)
          $display("%0t: last exp %b got %b", $time, want.fin, got.fin);
        if (got !== want) errors++;
      end
    end
  end

  initial begin
    #36_000_000;
    $display("timeout with %0d records outstanding", tree_q.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    join_rec_t zero_tree[$];
    int n, kind;
    bit more;

    // all-zero 3x3: first pair wins the tie, new cluster 3 in slot 0
    zero_tree.push_back(mk_rec(0, 1, 0, 0, 1'b0));
    zero_tree.push_back(mk_rec(3, 2, 0, 0, 1'b1));

    rows = '{
      '{OP_TAXA, 32'd0}, '{OP_CLAMP, 32'd0},
      '{OP_ENTRY, 32'd0}, '{OP_ENTRY, 32'd0}, '{OP_ENTRY, 32'd0},
      '{OP_ENTRY, 32'd0}, '{OP_ENTRY, 32'd0}, '{OP_ENTRY, 32'd0},
      '{OP_ENTRY, 32'd0}, '{OP_ENTRY, 32'd0}, '{OP_ENTRY_TYPED, 32'd0},
      // saturating, asymmetric, negative entries with clamping on
      '{OP_CLAMP, 32'hFFFF_FFFF}, '{OP_TAXA, 32'd3},
      '{OP_ENTRY, 32'h0000_0000}, '{OP_ENTRY, 32'h7FFF_FFFF}, '{OP_ENTRY, 32'h8000_0000},
      '{OP_ENTRY, 32'h7FFF_FFFF}, '{OP_ENTRY, 32'h0000_0000}, '{OP_ENTRY, 32'h0000_0001},
      '{OP_ENTRY, 32'h8000_0000}, '{OP_ENTRY, 32'hFFFF_FFFF}, '{OP_ENTRY, 32'h0000_0000},
      // same extremes without clamping, then a load cut short by a taxa write
      '{OP_CLAMP, 32'd0}, '{OP_TAXA, 32'd3},
      '{OP_ENTRY, 32'h8000_0000}, '{OP_ENTRY, 32'h7FFF_FFFF}, '{OP_ENTRY, 32'h8000_0000},
      '{OP_ENTRY, 32'h7FFF_FFFF}, '{OP_ENTRY, 32'h8000_0000}, '{OP_ENTRY, 32'h7FFF_FFFF},
      '{OP_ENTRY, 32'h8000_0000}, '{OP_ENTRY, 32'h7FFF_FFFF}, '{OP_ENTRY, 32'h8000_0000},
      '{OP_TAXA, 32'd4}, '{OP_ENTRY, 32'h0001_0000}, '{OP_ENTRY, 32'h0002_0000}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[k]) begin
      if (rows[k].op == OP_TAXA || rows[k].op == OP_CLAMP) begin
        wait_drained();
        reg_write(rows[k].op == OP_TAXA ? REG_TAXA : REG_CLAMP, rows[k].val);
      end else begin
        more = (k + 1 < rows.size()) && (rows[k + 1].op inside {OP_ENTRY, OP_ENTRY_TYPED});
        send_entry(rows[k].val, more, rows[k].op == OP_ENTRY_TYPED, zero_tree);
      end
    end

    // random trees, small sizes; sometimes back to back, sometimes reconfigured
    while (items_sent < 310) begin
      if ($urandom_range(0, 2) == 0 || items_sent < 40) begin
        wait_drained();
        n = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 7);
        reg_write(REG_TAXA, n);
        reg_write(REG_CLAMP, $urandom);
      end
      kind = $urandom_range(0, 9);
      kind = (kind < 7) ? 0 : (kind < 9) ? 2 : 1;
      send_matrix(nj_taxa, kind);
    end

    wait_drained();
    $display("%0d entries sent, %0d trees built, %0d join records checked",
             items_sent, trees_built, recs_seen);
    $display("sizes 3..7 with small sizes raised to 3, clamping on and off, "
             , "saturating, asymmetric and cut-short loads");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
